[rtl/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// sitda_pkg: shared definitions for the signed integer to decimal text unit
// Holds the default input width, the ASCII codes and the cell control
// bundle that the top level sends down the digit chain.
// ----------------------------------------------------------------------------
package sitda_pkg;

    // Default width of the signed input value
    localparam int VALUE_BITS_DEF = 32;

    // Width of one BCD digit and of one emitted character code
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 6;

    // Character codes
    localparam logic [CHAR_W-1:0] CODE_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CODE_ZERO  = 6'd48;

    // Control bundle for every cell of the digit chain
    typedef struct packed {
        logic clear;        // zero the digit
        logic bit_shift;    // one double-dabble step: adjust, then shift a bit in
        logic digit_shift;  // take the lower neighbor's digit
    } t_cell_ctrl;

endpackage

[rtl/sitda_in_if.sv]
// ----------------------------------------------------------------------------
// sitda_in_if: input channel of the conversion unit
// Carries one signed value per transfer under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sitda_in_if #(
    parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[rtl/sitda_out_if.sv]
// ----------------------------------------------------------------------------
// sitda_out_if: output channel of the conversion unit
// Carries one ASCII character and its end-of-text flag per transfer.
// ----------------------------------------------------------------------------
interface sitda_out_if;
    logic                          valid;
    logic                          ready;
    logic [sitda_pkg::CHAR_W-1:0]  char_code;
    logic                          last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

[rtl/sitda_cell.sv]
// ----------------------------------------------------------------------------
// sitda_cell: one decimal digit of the conversion chain
// Holds a BCD digit. In a binary step it applies the add-3 correction and
// shifts one bit in from the lower neighbor, passing its top bit upward.
// In a digit step it takes the lower neighbor's whole digit.
// ----------------------------------------------------------------------------
module sitda_cell (
    input  logic                            i_clk,
    input  sitda_pkg::t_cell_ctrl           i_ctrl,
    input  logic                            i_bit,
    input  logic [sitda_pkg::DIGIT_W-1:0]   i_digit,
    output logic                            o_bit,
    output logic [sitda_pkg::DIGIT_W-1:0]   o_digit
);
    import sitda_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] adj;

    // Correct digits of five and up so the shift carries properly
    assign adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_bit = adj[DIGIT_W-1];

    // Select next digit
    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.bit_shift) begin
            n_digit = {adj[DIGIT_W-2:0], i_bit};
        end else if (i_ctrl.digit_shift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_digit = r_digit;

endmodule

[rtl/signed_int_to_decimal_ascii_unit.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit: signed integer to decimal ASCII text
// Converts one two's complement value into its decimal characters, most
// significant first, with a leading minus sign for negative values.
// ----------------------------------------------------------------------------
// One value is converted at a time. After the input transfer the magnitude
// is shifted bit by bit through a chain of BCD digit cells (double dabble).
// The chain then shifts up one digit per cycle to drop leading zeros, and
// emits one character per cycle from its top cell while the output is free,
// after a minus sign for a negative value. A new value is taken once the
// last character has been loaded into the output register. Zero gives the
// single character '0'; the most negative value is handled exactly. Each
// run ends with last_char set.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sitda_in_if.sink    i_in,
    sitda_out_if.source o_out
);
    import sitda_pkg::*;

    // Digits of 2^(VALUE_BITS-1), the largest magnitude
    localparam int NDIG  = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int LFT_W = $clog2(NDIG + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [VALUE_BITS-1:0]  r_mag, n_mag;
    logic                   r_neg, n_neg;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [LFT_W-1:0]       r_left, n_left;
    logic                   r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]      r_char, n_char;
    logic                   r_last, n_last;

    t_cell_ctrl             cell_ctrl;
    logic [NDIG:0]          chain_bit;
    logic [DIGIT_W-1:0]     chain_digit [NDIG+1];
    logic [DIGIT_W-1:0]     top_digit;
    logic                   out_free;
    logic                   in_fire;
    logic [VALUE_BITS-1:0]  in_raw;

    // Digit chain: cell 0 is the least significant digit
    assign chain_bit[0]   = r_mag[VALUE_BITS-1];
    assign chain_digit[0] = '0;

    for (genvar g = 0; g < NDIG; g++) begin : g_cell
        sitda_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl),
            .i_bit   (chain_bit[g]),
            .i_digit (chain_digit[g]),
            .o_bit   (chain_bit[g+1]),
            .o_digit (chain_digit[g+1])
        );
    end

    assign top_digit = chain_digit[NDIG];
    assign out_free  = !r_out_valid || o_out.ready;
    assign in_fire   = i_in.valid && i_in.ready;
    assign in_raw    = i_in.value;

    // Sequence: accept, convert, skip leading zeros, sign, emit
    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        cell_ctrl   = '0;

        // Drop the output once transferred
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_neg           = in_raw[VALUE_BITS-1];
                    n_mag           = in_raw[VALUE_BITS-1] ? (~in_raw + 1'b1) : in_raw;
                    n_cnt           = CNT_W'(VALUE_BITS);
                    cell_ctrl.clear = 1'b1;
                    n_state         = ST_CONV;
                end
            end
            ST_CONV: begin
                cell_ctrl.bit_shift = 1'b1;
                n_mag               = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_cnt               = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_left  = LFT_W'(NDIG);
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_digit == '0 && r_left > LFT_W'(1)) begin
                    cell_ctrl.digit_shift = 1'b1;
                    n_left                = r_left - 1'b1;
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = CODE_MINUS;
                    n_last      = 1'b0;
                    n_state     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_char                = CODE_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
                    n_last                = (r_left == LFT_W'(1));
                    cell_ctrl.digit_shift = 1'b1;
                    n_left                = r_left - 1'b1;
                    if (r_left == LFT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_char;
    assign o_out.last_char = r_last;

endmodule
